@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/pbc_pkg.sv @@
// Types, constants and the error probability table of the pileup base counter.
`timescale 1ns / 1ps
`default_nettype none
package pbc_pkg;

    // Fixed geometry of one counter row.
    localparam int BASES_PER_POSITION = 4;
    localparam int COUNT_W            = 32;
    localparam int POS_W              = 31;
    localparam int ERR_W              = 48;
    localparam int PROB_W             = 32;
    localparam int QUAL_CAP           = 93;
    localparam int QIDX_W             = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_START  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_END    = 2'd1;
    localparam logic [1:0] CFG_MAPQ_FLOOR    = 2'd2;
    localparam logic [1:0] CFG_MIN_BASE_QUAL = 2'd3;
    localparam logic [POS_W-1:0] WINDOW_END_RESET = 31'd4095;

    // Request kinds carried in tuser.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // nt16 base codes.
    localparam logic [3:0] BASE_CODE_A = 4'd1;
    localparam logic [3:0] BASE_CODE_C = 4'd2;
    localparam logic [3:0] BASE_CODE_G = 4'd4;
    localparam logic [3:0] BASE_CODE_T = 4'd8;

    // Unmapped, secondary, qc-fail and duplicate flag bits.
    localparam logic [15:0] FLAG_DROP_MASK = 16'h0704;

    typedef logic [BASES_PER_POSITION-1:0][COUNT_W-1:0] t_row;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_pbc_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic commit;
        logic clear_en;
    } t_pbc_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_pbc_sts;

    // 10^(-k/10) * 2^31, rounded to nearest.
    localparam longint unsigned TENTH_POW_Q31 [0:9] = '{
        64'd2147483648, 64'd1705806895, 64'd1354970580, 64'd1076291389,
        64'd854928639,  64'd679093957,  64'd539423504,  64'd428479319,
        64'd340353221,  64'd270352174
    };

    typedef logic [PROB_W-1:0] t_prob_table [0:QUAL_CAP];

    // Builds 10^(-q/10) in Q.31 for every capped quality: rounded division
    // of the fractional decade by the whole decade.
    function automatic t_prob_table build_prob_table();
        t_prob_table      tbl;
        longint unsigned  b;
        longint unsigned  v;
        int               q;
        for (q = 0; q <= QUAL_CAP; q++) begin
            b = TENTH_POW_Q31[q % 10];
            case (q / 10)
                0: v = b;
                1: v = (b + 64'd5) / 10;
                2: v = (b + 64'd50) / 100;
                3: v = (b + 64'd500) / 1000;
                4: v = (b + 64'd5000) / 10000;
                5: v = (b + 64'd50000) / 100000;
                6: v = (b + 64'd500000) / 1000000;
                7: v = (b + 64'd5000000) / 10000000;
                8: v = (b + 64'd50000000) / 100000000;
                9: v = (b + 64'd500000000) / 1000000000;
                default: v = b;
            endcase
            tbl[q] = v[PROB_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_prob_table ERR_PROB_TABLE = build_prob_table();

endpackage
`default_nettype wire

@@ rtl/core/pbc_count_mem.sv @@
// Counter store: one row of four base counters per window position.
`timescale 1ns / 1ps
`default_nettype none
module pbc_count_mem #(
    parameter  int WINDOW_DEPTH = 4096,
    localparam int ROW_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_wr_en,
    input  wire  [ROW_W-1:0]    i_wr_addr,
    input  wire  pbc_pkg::t_row i_wr_data,
    input  wire                 i_rd_en,
    input  wire  [ROW_W-1:0]    i_rd_addr,
    output pbc_pkg::t_row       o_rd_data
);

    pbc_pkg::t_row r_mem [0:WINDOW_DEPTH-1];
    pbc_pkg::t_row r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/core/pbc_ctrl.sv @@
// Controller state machine: clearing pass, capture, lookup and update.
`timescale 1ns / 1ps
`default_nettype none
module pbc_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire  pbc_pkg::t_pbc_sts i_sts,
    output pbc_pkg::t_pbc_cmd       o_cmd
);

    pbc_pkg::t_pbc_state r_state;
    pbc_pkg::t_pbc_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbc_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = pbc_pkg::ST_IDLE;
                end
            end
            pbc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pbc_pkg::ST_LOOKUP;
                end
            end
            pbc_pkg::ST_LOOKUP: begin
                n_state = pbc_pkg::ST_UPDATE;
            end
            pbc_pkg::ST_UPDATE: begin
                if (i_sts.out_free) begin
                    n_state = pbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pbc_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            pbc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            pbc_pkg::ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            pbc_pkg::ST_UPDATE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/pbc_datapath.sv @@
// Datapath: configuration, filters, error table, accumulators and result beat.
`timescale 1ns / 1ps
`default_nettype none
module pbc_datapath #(
    parameter  int WINDOW_DEPTH = 4096,
    localparam int ROW_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Configuration writes
    input  wire                     i_cfg_wr_en,
    input  wire  [1:0]              i_cfg_index,
    input  wire  [30:0]             i_cfg_data,
    // Input beat fields
    input  wire                     i_req_type,
    input  wire  [30:0]             i_ref_position,
    input  wire  [3:0]              i_base_code,
    input  wire  [7:0]              i_base_qual,
    input  wire  [7:0]              i_read_mapq,
    input  wire  [15:0]             i_read_flags,
    // Control
    input  wire  pbc_pkg::t_pbc_cmd i_cmd,
    output pbc_pkg::t_pbc_sts       o_sts,
    // Counter store
    output logic                    o_mem_wr_en,
    output logic [ROW_W-1:0]        o_mem_wr_addr,
    output pbc_pkg::t_row           o_mem_wr_data,
    output logic                    o_mem_rd_en,
    output logic [ROW_W-1:0]        o_mem_rd_addr,
    input  wire  pbc_pkg::t_row     i_mem_rd_data,
    // Result beat
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [215:0]            o_out_data
);

    localparam logic [pbc_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [pbc_pkg::ERR_W-1:0]   ERR_MAX   = '1;

    // Configuration registers
    logic [30:0] r_win_start;
    logic [30:0] r_win_end;
    logic [7:0]  r_mapq_floor;
    logic [7:0]  r_min_qual;

    // Captured request
    logic        r_req;
    logic [30:0] r_pos;
    logic [3:0]  r_code;
    logic [7:0]  r_qual;
    logic [7:0]  r_mapq;
    logic [15:0] r_flags;

    // Lookup stage results
    logic                        r_inside;
    logic                        r_keep;
    logic [ROW_W-1:0]            r_row;
    logic [1:0]                  r_lane;
    logic                        r_lane_ok;
    logic [pbc_pkg::PROB_W-1:0]  r_prob;

    // Running totals and clearing pointer
    logic [pbc_pkg::ERR_W-1:0]   r_err_acc;
    logic [pbc_pkg::COUNT_W-1:0] r_total;
    logic [ROW_W-1:0]            r_clr_row;

    // Result register
    logic         r_out_valid;
    logic [215:0] r_out_data;

    logic [30:0]                 offset;
    logic                        in_win;
    logic                        keep;
    logic [ROW_W-1:0]            row;
    logic [1:0]                  lane;
    logic                        lane_ok;
    logic [pbc_pkg::QIDX_W-1:0]  qidx;
    pbc_pkg::t_row               n_row;
    pbc_pkg::t_row               out_row;
    logic [pbc_pkg::ERR_W:0]     err_sum;
    logic [pbc_pkg::ERR_W-1:0]   n_err_acc;
    logic [pbc_pkg::COUNT_W-1:0] n_total;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start  <= '0;
            r_win_end    <= pbc_pkg::WINDOW_END_RESET;
            r_mapq_floor <= '0;
            r_min_qual   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pbc_pkg::CFG_WINDOW_START:  r_win_start  <= i_cfg_data;
                pbc_pkg::CFG_WINDOW_END:    r_win_end    <= i_cfg_data;
                pbc_pkg::CFG_MAPQ_FLOOR:    r_mapq_floor <= i_cfg_data[7:0];
                pbc_pkg::CFG_MIN_BASE_QUAL: r_min_qual   <= i_cfg_data[7:0];
                default: begin
                    r_min_qual <= r_min_qual;
                end
            endcase
        end
    end

    // Capture the accepted input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req   <= i_req_type;
            r_pos   <= i_ref_position;
            r_code  <= i_base_code;
            r_qual  <= i_base_qual;
            r_mapq  <= i_read_mapq;
            r_flags <= i_read_flags;
        end
    end

    // Window check and filters on the captured request.
    always_comb begin
        offset  = r_pos - r_win_start;
        in_win  = (r_pos >= r_win_start) && (r_pos <= r_win_end) &&
                  ({1'b0, offset} < 32'(WINDOW_DEPTH));
        row     = offset[ROW_W-1:0];
        keep    = (r_req == pbc_pkg::REQ_ADD) && in_win &&
                  (r_mapq >= r_mapq_floor) &&
                  ((r_flags & pbc_pkg::FLAG_DROP_MASK) == '0) &&
                  (r_qual >= r_min_qual);
        qidx    = (r_qual > 8'(pbc_pkg::QUAL_CAP)) ? pbc_pkg::QIDX_W'(pbc_pkg::QUAL_CAP)
                                                   : r_qual[pbc_pkg::QIDX_W-1:0];
        lane    = 2'd0;
        lane_ok = 1'b1;
        case (r_code)
            pbc_pkg::BASE_CODE_A: lane = 2'd0;
            pbc_pkg::BASE_CODE_C: lane = 2'd1;
            pbc_pkg::BASE_CODE_G: lane = 2'd2;
            pbc_pkg::BASE_CODE_T: lane = 2'd3;
            default: lane_ok = 1'b0;
        endcase
    end

    // Lookup stage registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_inside  <= in_win;
            r_keep    <= keep;
            r_row     <= row;
            r_lane    <= lane;
            r_lane_ok <= lane_ok;
            r_prob    <= pbc_pkg::ERR_PROB_TABLE[qidx];
        end
    end

    // Row update with saturating counters, and the reported counts.
    always_comb begin
        for (int l = 0; l < pbc_pkg::BASES_PER_POSITION; l++) begin
            if (r_keep && r_lane_ok && (r_lane == 2'(l)) &&
                (i_mem_rd_data[l] != COUNT_MAX)) begin
                n_row[l] = i_mem_rd_data[l] + 32'd1;
            end else begin
                n_row[l] = i_mem_rd_data[l];
            end
        end
        out_row = r_inside ? n_row : '0;
    end

    // Saturating error sum and base total.
    always_comb begin
        err_sum   = {1'b0, r_err_acc} + (pbc_pkg::ERR_W + 1)'(r_prob);
        n_err_acc = err_sum[pbc_pkg::ERR_W] ? ERR_MAX : err_sum[pbc_pkg::ERR_W-1:0];
        n_total   = (r_total == COUNT_MAX) ? r_total : r_total + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_acc <= '0;
            r_total   <= '0;
        end else if (i_cmd.commit && r_keep) begin
            r_err_acc <= n_err_acc;
            r_total   <= n_total;
        end
    end

    // Clearing pass pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear_en && !o_sts.clear_last) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
        end
    end

    // Counter store ports: clearing writes zeros, commit writes the bumped row.
    always_comb begin
        o_mem_rd_en   = i_cmd.lookup;
        o_mem_rd_addr = row;
        o_mem_wr_en   = i_cmd.clear_en || (i_cmd.commit && r_keep && r_lane_ok);
        o_mem_wr_addr = i_cmd.clear_en ? r_clr_row : r_row;
        o_mem_wr_data = i_cmd.clear_en ? '0 : n_row;
    end

    // Result register; it holds until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {7'd0,
                           r_keep ? n_total : r_total,
                           r_keep ? n_err_acc : r_err_acc,
                           out_row[3], out_row[2], out_row[1], out_row[0],
                           r_keep};
        end
    end

    assign o_sts.clear_last = (r_clr_row == ROW_W'(WINDOW_DEPTH - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule
`default_nettype wire

@@ rtl/core/pileup_base_counter.sv @@
// Top level of the pileup base counter: per-position A/C/G/T histogram.
//
//   Channel   Direction  Ports                     Content
//   s_axis    in         tvalid/tready/tdata/tuser one read base or a count query
//   m_axis    out        tvalid/tready/tdata       counts, error sum and total
//   cfg       in         wr_en/index/data          window and quality thresholds
//
// An item goes through capture, counter row read, then row update and result
// load; the read-modify-write through the registered store read sets this order.
// After reset a clearing pass zeroes the store, one row a cycle, from row 0
// to row WINDOW_DEPTH-1; no input beat is taken until it ends.
// The update waits while the previous result beat is still unaccepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pileup_base_counter #(
    parameter  int WINDOW_DEPTH = 4096,
    localparam int ROW_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input stream
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [30:0] ref_position, [34:31] base_code, [42:35] base_qual,
    // [50:43] read_mapq, [66:51] read_flags, [71:67] zero
    input  wire  [71:0]  i_s_axis_tdata,
    // [0] req_type
    input  wire          i_s_axis_tuser,
    // Result stream
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [0] base_accepted, [32:1] count_a, [64:33] count_c, [96:65] count_g,
    // [128:97] count_t, [176:129] error_sum, [208:177] base_total, [215:209] zero
    output logic [215:0] o_m_axis_tdata,
    // Configuration
    input  wire          i_cfg_wr_en,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [30:0]  i_cfg_data
);

    pbc_pkg::t_pbc_cmd cmd;
    pbc_pkg::t_pbc_sts sts;

    logic             mem_wr_en;
    logic [ROW_W-1:0] mem_wr_addr;
    pbc_pkg::t_row    mem_wr_data;
    logic             mem_rd_en;
    logic [ROW_W-1:0] mem_rd_addr;
    pbc_pkg::t_row    mem_rd_data;

    // Sequencer.
    pbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Filters, totals and result register.
    pbc_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_s_axis_tuser),
        .i_ref_position (i_s_axis_tdata[30:0]),
        .i_base_code    (i_s_axis_tdata[34:31]),
        .i_base_qual    (i_s_axis_tdata[42:35]),
        .i_read_mapq    (i_s_axis_tdata[50:43]),
        .i_read_flags   (i_s_axis_tdata[66:51]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_mem_wr_en    (mem_wr_en),
        .o_mem_wr_addr  (mem_wr_addr),
        .o_mem_wr_data  (mem_wr_data),
        .o_mem_rd_en    (mem_rd_en),
        .o_mem_rd_addr  (mem_rd_addr),
        .i_mem_rd_data  (mem_rd_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_data     (o_m_axis_tdata)
    );

    // Counter store.
    pbc_count_mem #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_count_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // An accepted beat is looked up in the next cycle.
    `ASSERT_PROP(a_accept_then_lookup, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> cmd.lookup)
    // A result is only loaded when the result register can take it.
    `ASSERT_PROP(a_commit_needs_room, i_clk, i_rst_n, cmd.commit |-> sts.out_free)
    // A committed result shows up as a valid beat.
    `ASSERT_PROP(a_commit_then_valid, i_clk, i_rst_n, cmd.commit |=> o_m_axis_tvalid)
    // No input is taken while the store is still being cleared.
    `ASSERT_NEVER(a_no_ready_in_clear, i_clk, i_rst_n, cmd.clear_en && o_s_axis_tready)

endmodule
`default_nettype wire
